@@ rtl/catmull_rom_point_eval_assert.svh @@
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator assertion macros
// Short forms for clocked implications with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_POINT_EVAL_ASSERT_SVH
`define CATMULL_ROM_POINT_EVAL_ASSERT_SVH

// Same-cycle implication.
`define CRPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("crpe checker: same-cycle assertion failed");

// Next-cycle implication.
`define CRPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("crpe checker: next-cycle assertion failed");

`endif

@@ rtl/crpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator package
// Field layout, datapath widths and item kinds shared by the RTL and checker.
// ----------------------------------------------------------------------------
package crpe_pkg;

  localparam int CoordBits = 32;
  localparam int FracBits  = 16;
  localparam int TBits     = FracBits + 1;
  localparam int SegBits   = 8;
  localparam int CountBits = 9;
  localparam int NumAxes   = 3;
  localparam int PointW    = NumAxes * CoordBits;
  localparam int NumPoints = 256;

  localparam int NumBanks  = 4;
  localparam int BankSelW  = 2;
  localparam int BankDepth = NumPoints / NumBanks;
  localparam int BankAddrW = SegBits - BankSelW;

  localparam int InDataW  = 136;
  localparam int InUserW  = 1;
  localparam int OutDataW = PointW;
  localparam int OutUserW = 2;

  localparam int WrIdxLsb = 0;
  localparam int PointLsb = 8;
  localparam int SegLsb   = PointLsb + PointW;
  localparam int TLsb     = SegLsb + SegBits;

  localparam int UserClamped = 0;
  localparam int UserSat     = 1;

  localparam int C01W   = CoordBits + 2;
  localparam int C23W   = CoordBits + 4;
  localparam int HaW    = C23W + FracBits + 2;
  localparam int HbW    = HaW + FracBits;
  localparam int LoW    = HbW / 2;
  localparam int HiW    = HbW - LoW;
  localparam int PloW   = LoW + TBits;
  localparam int PhiW   = HiW + TBits + 1;
  localparam int SumW   = HbW + TBits + 1;
  localparam int ShiftR = 3 * FracBits + 1;
  localparam int ResW   = SumW - ShiftR;

  localparam logic [CountBits-1:0] MinCount = CountBits'(4);
  localparam logic [CountBits-1:0] MaxCount = CountBits'(NumPoints);
  localparam logic [TBits-1:0]     ParamOne = TBits'(1) << FracBits;

  localparam logic [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

  typedef logic [PointW-1:0]           point_t;
  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic {
    KindWrite = 1'b0,
    KindEval  = 1'b1
  } kind_e;

endpackage

@@ rtl/catmull_rom_point_eval.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator
// Accepts one item per cycle unless a held output stalls it; an evaluate item
// passes through registers for the banked table read, coefficients, three Horner
// multiply stages with a split last product, and the final sum with saturation.
// Reset clears the pipeline valid bits and sets point_count to 4; the point
// table is not cleared, so points must be written before they are used.
// ----------------------------------------------------------------------------
module catmull_rom_point_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crpe_pkg::CountBits-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // write_index, point_x, point_y, point_z, segment_start, param_t, zero pad
  input  logic [crpe_pkg::InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [crpe_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_z
  output logic [crpe_pkg::OutDataW-1:0] m_axis_tdata,
  // was_clamped, was_saturated
  output logic [crpe_pkg::OutUserW-1:0] m_axis_tuser
);
  import crpe_pkg::*;

  logic                 adv;
  logic                 in_accept;
  kind_e                in_kind;
  logic                 wr_en;
  logic [SegBits-1:0]   wr_idx;
  point_t               wr_point;
  logic [CountBits-1:0] point_count_q;
  logic [CountBits-1:0] cnt_eff;
  logic [CountBits-1:0] last_idx;
  logic [SegBits-1:0]   in_seg;
  logic [SegBits-1:0]   sel_idx;
  logic [SegBits-1:0]   base_idx;
  logic [TBits-1:0]     in_t;
  logic [TBits-1:0]     t_sat;
  logic                 in_clamp;
  logic [BankAddrW-1:0] rd_addr [NumBanks];

  logic                rd_valid_q, rd_clamp_q;
  logic [TBits-1:0]    rd_t_q;
  logic [BankSelW-1:0] rd_rot_q;
  point_t              rd_q [NumBanks];
  point_t              pt_rot [4];

  logic                   cf_valid_q, cf_clamp_q;
  logic [TBits-1:0]       cf_t_q;
  logic signed [C01W-1:0] cf_c0_d [NumAxes], cf_c0_q [NumAxes];
  logic signed [C01W-1:0] cf_c1_d [NumAxes], cf_c1_q [NumAxes];
  logic signed [C23W-1:0] cf_c2_d [NumAxes], cf_c2_q [NumAxes];
  logic signed [C23W-1:0] cf_c3_d [NumAxes], cf_c3_q [NumAxes];

  logic                   ha_valid_q, ha_clamp_q;
  logic [TBits-1:0]       ha_t_q;
  logic signed [HaW-1:0]  ha_acc_d [NumAxes], ha_acc_q [NumAxes];
  logic signed [C01W-1:0] ha_c1_q [NumAxes];
  logic signed [C01W-1:0] ha_c0_q [NumAxes];

  logic                   hb_valid_q, hb_clamp_q;
  logic [TBits-1:0]       hb_t_q;
  logic signed [HbW-1:0]  hb_acc_d [NumAxes], hb_acc_q [NumAxes];
  logic signed [C01W-1:0] hb_c0_q [NumAxes];

  logic                   pp_valid_q, pp_clamp_q;
  logic [PloW-1:0]        pp_lo_d [NumAxes], pp_lo_q [NumAxes];
  logic signed [PhiW-1:0] pp_hi_d [NumAxes], pp_hi_q [NumAxes];
  logic signed [C01W-1:0] pp_c0_q [NumAxes];

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_d, out_data_q;
  logic [OutUserW-1:0] out_user_d, out_user_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_accept     = s_axis_tvalid && adv;
  assign in_kind       = kind_e'(s_axis_tuser[0]);
  assign wr_en         = in_accept && (in_kind == KindWrite);
  assign wr_idx        = s_axis_tdata[WrIdxLsb +: SegBits];
  assign wr_point      = s_axis_tdata[PointLsb +: PointW];
  assign in_seg        = s_axis_tdata[SegLsb +: SegBits];
  assign in_t          = s_axis_tdata[TLsb +: TBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= MinCount;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (point_count_q < MinCount) begin
      cnt_eff = MinCount;
    end else if (point_count_q > MaxCount) begin
      cnt_eff = MaxCount;
    end else begin
      cnt_eff = point_count_q;
    end
    last_idx = cnt_eff - CountBits'(2);
    in_clamp = (in_seg == '0) || ({1'b0, in_seg} >= last_idx);
    if (!in_clamp) begin
      sel_idx = in_seg;
    end else if (in_seg == '0) begin
      sel_idx = SegBits'(1);
    end else begin
      sel_idx = last_idx[SegBits-1:0];
    end
    base_idx = sel_idx - SegBits'(1);
    t_sat    = (in_t > ParamOne) ? ParamOne : in_t;
    for (int b = 0; b < NumBanks; b++) begin
      rd_addr[b] = BankAddrW'(SegBits'(base_idx + {{(SegBits-BankSelW){1'b0}},
                   BankSelW'(BankSelW'(b) - base_idx[BankSelW-1:0])}) >> BankSelW);
    end
  end

  // Four interleaved banks: the points s-1 .. s+2 fall in distinct banks.
  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    point_t bank_mem_q [BankDepth];

    always_ff @(posedge clk_i) begin
      if (wr_en && (wr_idx[BankSelW-1:0] == BankSelW'(b))) begin
        bank_mem_q[wr_idx[SegBits-1:BankSelW]] <= wr_point;
      end
      if (adv) begin
        rd_q[b] <= bank_mem_q[rd_addr[b]];
      end
    end
  end

  always_comb begin
    case (rd_rot_q)
      2'd0: begin
        pt_rot[0] = rd_q[0]; pt_rot[1] = rd_q[1]; pt_rot[2] = rd_q[2]; pt_rot[3] = rd_q[3];
      end
      2'd1: begin
        pt_rot[0] = rd_q[1]; pt_rot[1] = rd_q[2]; pt_rot[2] = rd_q[3]; pt_rot[3] = rd_q[0];
      end
      2'd2: begin
        pt_rot[0] = rd_q[2]; pt_rot[1] = rd_q[3]; pt_rot[2] = rd_q[0]; pt_rot[3] = rd_q[1];
      end
      default: begin
        pt_rot[0] = rd_q[3]; pt_rot[1] = rd_q[0]; pt_rot[2] = rd_q[1]; pt_rot[3] = rd_q[2];
      end
    endcase
  end

  always_comb begin
    coord_t p0, p1, p2, p3;
    for (int a = 0; a < NumAxes; a++) begin
      p0 = coord_t'(pt_rot[0][a*CoordBits +: CoordBits]);
      p1 = coord_t'(pt_rot[1][a*CoordBits +: CoordBits]);
      p2 = coord_t'(pt_rot[2][a*CoordBits +: CoordBits]);
      p3 = coord_t'(pt_rot[3][a*CoordBits +: CoordBits]);
      cf_c0_d[a] = C01W'(p1) <<< 1;
      cf_c1_d[a] = C01W'(p2) - C01W'(p0);
      cf_c2_d[a] = (C23W'(p0) <<< 1) - ((C23W'(p1) <<< 2) + C23W'(p1))
                 + (C23W'(p2) <<< 2) - C23W'(p3);
      cf_c3_d[a] = ((C23W'(p1) <<< 1) + C23W'(p1)) - ((C23W'(p2) <<< 1) + C23W'(p2))
                 + C23W'(p3) - C23W'(p0);
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      ha_acc_d[a] = cf_c3_q[a] * $signed({1'b0, cf_t_q})
                  + (HaW'(cf_c2_q[a]) <<< FracBits);
      hb_acc_d[a] = ha_acc_q[a] * $signed({1'b0, ha_t_q})
                  + (HbW'(ha_c1_q[a]) <<< (2 * FracBits));
      pp_lo_d[a]  = PloW'(hb_acc_q[a][LoW-1:0]) * PloW'(hb_t_q);
      pp_hi_d[a]  = $signed(hb_acc_q[a][HbW-1:LoW]) * $signed({1'b0, hb_t_q});
    end
  end

  // The final sum is floored by dropping its low bits, then saturated; a clamped item outputs p1 instead.
  always_comb begin
    logic [SumW-1:0]   sum;
    logic [ResW-1:0]   res;
    logic [ResW-CoordBits:0] hi;
    logic              sat_any;
    sat_any = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      sum = (SumW'(pp_hi_q[a]) <<< LoW) + SumW'(pp_lo_q[a])
          + (SumW'(pp_c0_q[a]) <<< (3 * FracBits));
      res = sum[SumW-1:ShiftR];
      hi  = res[ResW-1:CoordBits-1];
      if (pp_clamp_q) begin
        out_data_d[a*CoordBits +: CoordBits] = pp_c0_q[a][CoordBits:1];
      end else if ((&hi) || (~|hi)) begin
        out_data_d[a*CoordBits +: CoordBits] = res[CoordBits-1:0];
      end else begin
        sat_any = 1'b1;
        out_data_d[a*CoordBits +: CoordBits] = res[ResW-1] ? CoordMin : CoordMax;
      end
    end
    out_user_d              = '0;
    out_user_d[UserClamped] = pp_clamp_q;
    out_user_d[UserSat]     = sat_any && !pp_clamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      cf_valid_q  <= 1'b0;
      ha_valid_q  <= 1'b0;
      hb_valid_q  <= 1'b0;
      pp_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      rd_valid_q  <= in_accept && (in_kind == KindEval);
      cf_valid_q  <= rd_valid_q;
      ha_valid_q  <= cf_valid_q;
      hb_valid_q  <= ha_valid_q;
      pp_valid_q  <= hb_valid_q;
      out_valid_q <= pp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_clamp_q <= in_clamp;
      rd_t_q     <= t_sat;
      rd_rot_q   <= base_idx[BankSelW-1:0];
      cf_clamp_q <= rd_clamp_q;
      cf_t_q     <= rd_t_q;
      cf_c0_q    <= cf_c0_d;
      cf_c1_q    <= cf_c1_d;
      cf_c2_q    <= cf_c2_d;
      cf_c3_q    <= cf_c3_d;
      ha_clamp_q <= cf_clamp_q;
      ha_t_q     <= cf_t_q;
      ha_acc_q   <= ha_acc_d;
      ha_c1_q    <= cf_c1_q;
      ha_c0_q    <= cf_c0_q;
      hb_clamp_q <= ha_clamp_q;
      hb_t_q     <= ha_t_q;
      hb_acc_q   <= hb_acc_d;
      hb_c0_q    <= ha_c0_q;
      pp_clamp_q <= hb_clamp_q;
      pp_lo_q    <= pp_lo_d;
      pp_hi_q    <= pp_hi_d;
      pp_c0_q    <= hb_c0_q;
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ rtl/crpe_checker.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "catmull_rom_point_eval_assert.svh"

module crpe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_i,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [crpe_pkg::OutDataW-1:0] m_axis_tdata_i,
  input logic [crpe_pkg::OutUserW-1:0] m_axis_tuser_i
);
  import crpe_pkg::*;

  logic [CoordBits-1:0] ox, oy, oz;

  assign ox = m_axis_tdata_i[0*CoordBits +: CoordBits];
  assign oy = m_axis_tdata_i[1*CoordBits +: CoordBits];
  assign oz = m_axis_tdata_i[2*CoordBits +: CoordBits];

  // The input side only stalls when a finished item is held at the output.
  `CRPE_ASSERT_IMP(a_stall_from_output, clk_i, rst_ni, !s_axis_tready_i, m_axis_tvalid_i && !m_axis_tready_i)

  `CRPE_ASSERT_IMP(a_clamp_not_sat, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i[UserClamped], !m_axis_tuser_i[UserSat])

  `CRPE_ASSERT_IMP(a_sat_value, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i[UserSat], ox == CoordMax || ox == CoordMin || oy == CoordMax || oy == CoordMin || oz == CoordMax || oz == CoordMin)

  `CRPE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

endmodule

bind catmull_rom_point_eval crpe_checker u_crpe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata),
  .m_axis_tuser_i  (m_axis_tuser)
);
